// ===== rtl/ksct_pkg.sv =====
// shared types and codes for the keyed slot table
// no dependencies
package ksct_pkg;

  localparam int KEY_W = 32;
  localparam int DATA_W = 64;
  localparam int CNT32_W = 32;

  localparam logic [2:0] ACT_CREATE = 3'd0;
  localparam logic [2:0] ACT_LOOKUP = 3'd1;
  localparam logic [2:0] ACT_UPDATE = 3'd2;
  localparam logic [2:0] ACT_REMOVE = 3'd3;
  localparam logic [2:0] ACT_BEGIN = 3'd4;
  localparam logic [2:0] ACT_RESOLVE = 3'd5;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_NOT_FOUND = 3'd1;
  localparam logic [2:0] ST_STALE = 3'd2;
  localparam logic [2:0] ST_FULL = 3'd3;
  localparam logic [2:0] ST_ZERO_ID = 3'd4;

  typedef struct packed {
    logic [DATA_W-1:0]  tag;
    logic [DATA_W-1:0]  payload;
    logic [DATA_W-1:0]  interaction;
    logic [CNT32_W-1:0] begun;
    logic [CNT32_W-1:0] resolved;
  } ksct_entry_t;

  typedef struct packed {
    logic load_req;
    logic search;
    logic exec;
  } ksct_cmd_t;

endpackage

// ===== rtl/ksct_ram.sv =====
// generic single write port ram with registered read
// no dependencies
module ksct_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/ksct_ctrl.sv =====
// sequencing state machine for the keyed slot table
// depends on ksct_pkg
module ksct_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  output ksct_pkg::ksct_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_EXEC   = 3'b100
  } state_t;

  state_t state, state_next;
  logic   out_free;
  logic   fire;
  logic   accept;

  assign out_free = !out_valid || !out_stall;
  assign fire = (state == ST_EXEC) && out_free;
  assign in_stall = !((state == ST_IDLE) || fire);
  assign accept = in_valid && !in_stall;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        state_next = ST_EXEC;
      end
      ST_EXEC: begin
        if (fire) begin
          state_next = accept ? ST_SEARCH : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign cmd.load_req = accept;
  assign cmd.search = (state == ST_SEARCH);
  assign cmd.exec = fire;

`ifndef SYNTHESIS
  a_accept_to_search: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_SEARCH)
    else $error("accepted transaction did not start a search");
  a_search_to_exec: assert property (@(posedge clk) disable iff (rst)
    state == ST_SEARCH |=> state == ST_EXEC)
    else $error("search not followed by execute");
  a_fire_shows_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("executed transaction not presented");
`endif

endmodule

// ===== rtl/ksct_dp.sv =====
// slot table datapath: key match, free slot search, entry read-modify-write
// depends on ksct_pkg and ksct_ram
module ksct_dp #(
  parameter int SLOTS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ksct_pkg::ksct_cmd_t         cmd,
  input  logic [2:0]                  action,
  input  logic [31:0]                 key,
  input  logic [63:0]                 cmp_tag,
  input  logic [63:0]                 new_tag,
  input  logic [63:0]                 wr_payload,
  input  logic [63:0]                 iact_id,
  output logic [2:0]                  status,
  output logic [31:0]                 assigned_key,
  output logic [63:0]                 tag_out,
  output logic [63:0]                 payload_out,
  output logic [63:0]                 interaction_out,
  output logic [31:0]                 created_total,
  output logic [31:0]                 resolved_total,
  output logic [$clog2(SLOTS+1)-1:0]  live_entries
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int ENT_W = $bits(ksct_pkg::ksct_entry_t);

  logic [2:0]  req_action;
  logic [31:0] req_key;
  logic [63:0] req_expected;
  logic [63:0] req_new_tag;
  logic [63:0] req_new_payload;
  logic [63:0] req_iid;

  logic [SLOTS-1:0] slot_valid, slot_valid_next;
  logic [31:0]      slot_key [SLOTS];
  logic [31:0]      key_counter, key_counter_next;
  logic [CNT_W-1:0] occ, occ_next;

  logic [IDX_W-1:0] match_idx, free_idx, srch_idx, sel_idx;
  logic             match_hit, free_hit, srch_hit, sel_hit;

  ksct_pkg::ksct_entry_t ent_rd, ent_wr;
  logic [ENT_W-1:0]      ram_rdata;
  logic                  ram_we, key_we;

  logic [2:0]  st_c;
  logic [31:0] akey_c, ctot_c, rtot_c;
  logic [63:0] tag_c, pay_c, int_c;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_action <= action;
      req_key <= key;
      req_expected <= cmp_tag;
      req_new_tag <= new_tag;
      req_new_payload <= wr_payload;
      req_iid <= iact_id;
    end
  end

  // lowest matching live slot and lowest free slot
  always_comb begin
    match_idx = '0;
    match_hit = 1'b0;
    free_idx = '0;
    free_hit = 1'b0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (slot_valid[i] && slot_key[i] == req_key) begin
        match_hit = 1'b1;
        match_idx = IDX_W'(i);
      end
      if (!slot_valid[i]) begin
        free_hit = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign srch_idx = (req_action == ksct_pkg::ACT_CREATE) ? free_idx : match_idx;
  assign srch_hit = (req_action == ksct_pkg::ACT_CREATE) ? free_hit : match_hit;

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      sel_idx <= srch_idx;
      sel_hit <= srch_hit;
    end
  end

  ksct_ram #(
    .WIDTH(ENT_W),
    .DEPTH(SLOTS)
  ) u_entry_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(sel_idx),
    .wdata(ent_wr),
    .re   (cmd.search),
    .raddr(srch_idx),
    .rdata(ram_rdata)
  );

  assign ent_rd = ksct_pkg::ksct_entry_t'(ram_rdata);

  always_comb begin
    st_c = ksct_pkg::ST_NOT_FOUND;
    akey_c = '0;
    tag_c = '0;
    pay_c = '0;
    int_c = '0;
    ctot_c = '0;
    rtot_c = '0;
    ent_wr = ent_rd;
    ram_we = 1'b0;
    key_we = 1'b0;
    slot_valid_next = slot_valid;
    key_counter_next = key_counter;
    occ_next = occ;
    case (req_action)
      ksct_pkg::ACT_CREATE: begin
        if (!sel_hit) begin
          st_c = ksct_pkg::ST_FULL;
        end else begin
          st_c = ksct_pkg::ST_OK;
          akey_c = key_counter;
          key_counter_next = (key_counter == '1) ? 32'd1 : key_counter + 32'd1;
          ent_wr.tag = req_new_tag;
          ent_wr.payload = req_new_payload;
          ent_wr.interaction = '0;
          ent_wr.begun = '0;
          ent_wr.resolved = '0;
          ram_we = 1'b1;
          key_we = 1'b1;
          slot_valid_next[sel_idx] = 1'b1;
          occ_next = occ + CNT_W'(1);
        end
      end
      ksct_pkg::ACT_LOOKUP: begin
        if (sel_hit) begin
          st_c = ksct_pkg::ST_OK;
          tag_c = ent_rd.tag;
          pay_c = ent_rd.payload;
          int_c = ent_rd.interaction;
          ctot_c = ent_rd.begun;
          rtot_c = ent_rd.resolved;
        end
      end
      ksct_pkg::ACT_UPDATE: begin
        if (sel_hit) begin
          if (ent_rd.tag != req_expected) begin
            st_c = ksct_pkg::ST_STALE;
            tag_c = ent_rd.tag;
          end else begin
            st_c = ksct_pkg::ST_OK;
            ent_wr.tag = req_new_tag;
            ent_wr.payload = req_new_payload;
            ram_we = 1'b1;
          end
        end
      end
      ksct_pkg::ACT_REMOVE: begin
        if (sel_hit) begin
          st_c = ksct_pkg::ST_OK;
          slot_valid_next[sel_idx] = 1'b0;
          occ_next = occ - CNT_W'(1);
        end
      end
      ksct_pkg::ACT_BEGIN: begin
        if (req_iid == '0) begin
          st_c = ksct_pkg::ST_ZERO_ID;
        end else if (sel_hit) begin
          st_c = ksct_pkg::ST_OK;
          ent_wr.interaction = req_iid;
          ent_wr.begun = ent_rd.begun + 32'd1;
          ram_we = 1'b1;
        end
      end
      ksct_pkg::ACT_RESOLVE: begin
        if (sel_hit) begin
          st_c = ksct_pkg::ST_OK;
          int_c = ent_rd.interaction;
          if (ent_rd.interaction != '0) begin
            ent_wr.interaction = '0;
            ent_wr.resolved = ent_rd.resolved + 32'd1;
            ram_we = 1'b1;
          end
        end
      end
      default: begin
        st_c = ksct_pkg::ST_NOT_FOUND;
      end
    endcase
    ram_we = ram_we && cmd.exec;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
      key_counter <= 32'd1;
      occ <= '0;
    end else if (cmd.exec) begin
      slot_valid <= slot_valid_next;
      key_counter <= key_counter_next;
      occ <= occ_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && key_we) begin
      slot_key[sel_idx] <= key_counter;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status <= st_c;
      assigned_key <= akey_c;
      tag_out <= tag_c;
      payload_out <= pay_c;
      interaction_out <= int_c;
      created_total <= ctot_c;
      resolved_total <= rtot_c;
      live_entries <= occ_next;
    end
  end

`ifndef SYNTHESIS
  a_occ_matches_valid: assert property (@(posedge clk) disable iff (rst)
    occ == CNT_W'($countones(slot_valid)))
    else $error("live count disagrees with occupied slots");
  a_key_never_zero: assert property (@(posedge clk) disable iff (rst)
    key_counter != '0)
    else $error("key counter reached zero");
`endif

endmodule

// ===== rtl/keyed_slot_table_with_cas_unit.sv =====
// keyed slot table with compare-and-swap update, top level
// depends on ksct_pkg, ksct_ctrl, ksct_dp (and ksct_ram below it)
//
// usage:
//   input channel (in_valid / in_stall) carries one request transaction:
//   action, key, cmp_tag, new_tag, wr_payload, iact_id.
//   output channel (out_valid / out_stall) returns exactly one result
//   transaction per request, in request order.
//   a request is registered, searched for its slot, then executed as a
//   read-modify-write of the entry ram before its result is registered.
//   requests do not overlap: each finishes its execute step before the next search.
//   a new request is taken in the same cycle a result is loaded into
//   the output register.
//   when out_stall holds, a finished result waits in its execute step and
//   in_stall rises until the output register can take it.
//   reset clears all slot valid bits, sets the key counter to one and the
//   live count to zero; no ram clearing pass is needed, the block is ready
//   in the first cycle after reset.
module keyed_slot_table_with_cas_unit #(
  parameter int SLOTS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [2:0]                 action,
  input  logic [31:0]                key,
  input  logic [63:0]                cmp_tag,
  input  logic [63:0]                new_tag,
  input  logic [63:0]                wr_payload,
  input  logic [63:0]                iact_id,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [2:0]                 status,
  output logic [31:0]                assigned_key,
  output logic [63:0]                tag_out,
  output logic [63:0]                payload_out,
  output logic [63:0]                interaction_out,
  output logic [31:0]                created_total,
  output logic [31:0]                resolved_total,
  output logic [$clog2(SLOTS+1)-1:0] live_entries
);

  ksct_pkg::ksct_cmd_t cmd;

  ksct_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd)
  );

  ksct_dp #(
    .SLOTS(SLOTS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .action         (action),
    .key            (key),
    .cmp_tag        (cmp_tag),
    .new_tag        (new_tag),
    .wr_payload     (wr_payload),
    .iact_id        (iact_id),
    .status         (status),
    .assigned_key   (assigned_key),
    .tag_out        (tag_out),
    .payload_out    (payload_out),
    .interaction_out(interaction_out),
    .created_total  (created_total),
    .resolved_total (resolved_total),
    .live_entries   (live_entries)
  );

endmodule

// ===== tb/sv/ksct_result_checker.sv =====
// result checker for the keyed slot table: mirrors the table state and
// compares every result transaction against its own prediction
// depends on ksct_pkg
`timescale 1ns / 1ps

module ksct_result_checker #(
  parameter int SLOTS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  action,
  input  logic [31:0] key,
  input  logic [63:0] cmp_tag,
  input  logic [63:0] new_tag,
  input  logic [63:0] wr_payload,
  input  logic [63:0] iact_id,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  status,
  input  logic [31:0] assigned_key,
  input  logic [63:0] tag_out,
  input  logic [63:0] payload_out,
  input  logic [63:0] interaction_out,
  input  logic [31:0] created_total,
  input  logic [31:0] resolved_total,
  input  logic [4:0]  live_entries,
  output int          failures,
  output int          outstanding
);

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] akey;
    logic [63:0] tag;
    logic [63:0] payload;
    logic [63:0] interaction;
    logic [31:0] begun;
    logic [31:0] resolved;
    logic [4:0]  live;
  } slot_result_t;

  bit                    used [SLOTS];
  logic [31:0]           skey [SLOTS];
  ksct_pkg::ksct_entry_t entry [SLOTS];
  logic [31:0]           key_seq;
  logic [4:0]            occupied;
  int                    fail_cnt;

  slot_result_t awaited_results [$];

  task automatic clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      used[i] = 1'b0;
      skey[i] = '0;
      entry[i] = '0;
    end
    key_seq = 32'd1;
    occupied = '0;
  endtask

  task automatic table_step(input logic [2:0] act, input logic [31:0] k,
                            input logic [63:0] want_tag, input logic [63:0] ntag,
                            input logic [63:0] npay, input logic [63:0] iid,
                            output slot_result_t r);
    int s;
    r = '0;
    r.status = ksct_pkg::ST_NOT_FOUND;
    s = SLOTS;
    if (act == ksct_pkg::ACT_CREATE) begin
      for (int i = SLOTS - 1; i >= 0; i--) if (!used[i]) s = i;
      if (s == SLOTS) begin
        r.status = ksct_pkg::ST_FULL;
      end else begin
        r.akey = key_seq;
        key_seq = key_seq + 32'd1;
        if (key_seq == 32'd0) key_seq = 32'd1;
        used[s] = 1'b1;
        skey[s] = r.akey;
        entry[s] = '0;
        entry[s].tag = ntag;
        entry[s].payload = npay;
        occupied = occupied + 5'd1;
        r.status = ksct_pkg::ST_OK;
      end
    end else if (act == ksct_pkg::ACT_BEGIN && iid == '0) begin
      r.status = ksct_pkg::ST_ZERO_ID;
    end else if (act <= ksct_pkg::ACT_RESOLVE) begin
      // lowest matching slot wins
      for (int i = SLOTS - 1; i >= 0; i--) if (used[i] && skey[i] == k) s = i;
      if (s < SLOTS) begin
        r.status = ksct_pkg::ST_OK;
        case (act)
          ksct_pkg::ACT_LOOKUP: begin
            r.tag = entry[s].tag;
            r.payload = entry[s].payload;
            r.interaction = entry[s].interaction;
            r.begun = entry[s].begun;
            r.resolved = entry[s].resolved;
          end
          ksct_pkg::ACT_UPDATE: begin
            if (entry[s].tag != want_tag) begin
              r.tag = entry[s].tag;
              r.status = ksct_pkg::ST_STALE;
            end else begin
              entry[s].tag = ntag;
              entry[s].payload = npay;
            end
          end
          ksct_pkg::ACT_REMOVE: begin
            used[s] = 1'b0;
            skey[s] = '0;
            entry[s] = '0;
            occupied = occupied - 5'd1;
          end
          ksct_pkg::ACT_BEGIN: begin
            entry[s].interaction = iid;
            entry[s].begun = entry[s].begun + 32'd1;
          end
          default: begin
            r.interaction = entry[s].interaction;
            if (entry[s].interaction != '0) begin
              entry[s].interaction = '0;
              entry[s].resolved = entry[s].resolved + 32'd1;
            end
          end
        endcase
      end
    end
    r.live = occupied;
  endtask

  task automatic field_check(input string name, input logic [63:0] want_v,
                             input logic [63:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t %s: expected %h, actual %h", $time, name, want_v, got_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin : watch
    slot_result_t want;
    if (rst) begin
      clear_table();
      awaited_results.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (awaited_results.size() == 0) begin
          $display("%0t result transaction with no request outstanding", $time);
          fail_cnt++;
        end else begin
          want = awaited_results.pop_front();
          field_check("status", 64'(want.status), 64'(status));
          field_check("assigned_key", 64'(want.akey), 64'(assigned_key));
          field_check("tag_out", want.tag, tag_out);
          field_check("payload_out", want.payload, payload_out);
          field_check("interaction_out", want.interaction, interaction_out);
          field_check("created_total", 64'(want.begun), 64'(created_total));
          field_check("resolved_total", 64'(want.resolved), 64'(resolved_total));
          field_check("live_entries", 64'(want.live), 64'(live_entries));
        end
      end
      if (in_valid && !in_stall) begin
        table_step(action, key, cmp_tag, new_tag, wr_payload, iact_id, want);
        awaited_results.push_back(want);
      end
    end
    failures <= fail_cnt;
    outstanding <= awaited_results.size();
  end

endmodule

// ===== tb/sv/keyed_slot_table_with_cas_unit_tb.sv =====
// testbench top for keyed_slot_table_with_cas_unit: drives request
// transactions and random output stalls, gives the verdict
// depends on ksct_pkg, ksct_result_checker and the block under test
`timescale 1ns / 1ps

module keyed_slot_table_with_cas_unit_tb;

  localparam logic [2:0] ACT_RSVD_6 = 3'd6;
  localparam logic [2:0] ACT_RSVD_7 = 3'd7;
  localparam int RANDOM_ITEMS = 1700;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  action;
  logic [31:0] key;
  logic [63:0] cmp_tag;
  logic [63:0] new_tag;
  logic [63:0] wr_payload;
  logic [63:0] iact_id;
  logic        out_valid;
  logic        out_stall;
  logic [2:0]  status;
  logic [31:0] assigned_key;
  logic [63:0] tag_out;
  logic [63:0] payload_out;
  logic [63:0] interaction_out;
  logic [31:0] created_total;
  logic [31:0] resolved_total;
  logic [4:0]  live_entries;
  int          failures;
  int          outstanding;

  bit          quiet;
  logic [31:0] recent_keys [$];
  logic [2:0]  mid_acts [4] = '{ksct_pkg::ACT_LOOKUP, ksct_pkg::ACT_UPDATE,
                                ksct_pkg::ACT_BEGIN, ksct_pkg::ACT_RESOLVE};

  keyed_slot_table_with_cas_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .key(key), .cmp_tag(cmp_tag), .new_tag(new_tag),
    .wr_payload(wr_payload), .iact_id(iact_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .assigned_key(assigned_key), .tag_out(tag_out),
    .payload_out(payload_out), .interaction_out(interaction_out),
    .created_total(created_total), .resolved_total(resolved_total),
    .live_entries(live_entries)
  );

  ksct_result_checker u_chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .key(key), .cmp_tag(cmp_tag), .new_tag(new_tag),
    .wr_payload(wr_payload), .iact_id(iact_id),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .assigned_key(assigned_key), .tag_out(tag_out),
    .payload_out(payload_out), .interaction_out(interaction_out),
    .created_total(created_total), .resolved_total(resolved_total),
    .live_entries(live_entries),
    .failures(failures), .outstanding(outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("keyed_slot_table_with_cas_unit verification failed");
    $finish;
  end

  // keys handed out recently, used to aim requests at live entries
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall && assigned_key != '0) begin
      recent_keys.push_back(assigned_key);
      if (recent_keys.size() > 24) void'(recent_keys.pop_front());
    end
  end

  initial begin
    int n;
    out_stall <= 1'b0;
    @(posedge clk);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 15);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_tag();
    int r;
    r = $urandom_range(0, 9);
    if (r < 8) return 64'($urandom_range(0, 2));
    if (r == 8) return '1;
    return rand64();
  endfunction

  function automatic logic [31:0] pick_key();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1 || recent_keys.size() == 0) return $urandom;
    return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
  endfunction

  task automatic issue(input logic [2:0] act, input logic [31:0] k,
                       input logic [63:0] etag, input logic [63:0] ntag,
                       input logic [63:0] npay, input logic [63:0] iid);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    key <= k;
    cmp_tag <= etag;
    new_tag <= ntag;
    wr_payload <= npay;
    iact_id <= iid;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  initial begin
    int r;
    int create_w;
    int remove_w;
    logic [2:0] act;
    rst <= 1'b1;
    in_valid <= 1'b0;
    action <= ksct_pkg::ACT_LOOKUP;
    key <= '0;
    cmp_tag <= '0;
    new_tag <= '0;
    wr_payload <= '0;
    iact_id <= '0;
    quiet = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // fill the table, keys 1..16, then one create too many
    for (int i = 0; i < 16; i++)
      issue(ksct_pkg::ACT_CREATE, $urandom, rand64(), (i == 15) ? '1 : 64'(i),
            (i == 0) ? '1 : rand64(), rand64());
    issue(ksct_pkg::ACT_CREATE, '1, rand64(), rand64(), rand64(), rand64());
    issue(ksct_pkg::ACT_LOOKUP, 32'd16, rand64(), rand64(), rand64(), rand64());
    issue(ksct_pkg::ACT_UPDATE, 32'd1, '0, '1, '0, rand64());
    issue(ksct_pkg::ACT_UPDATE, 32'd1, '0, rand64(), rand64(), rand64());
    issue(ksct_pkg::ACT_BEGIN, 32'd2, rand64(), rand64(), rand64(), '1);
    issue(ksct_pkg::ACT_BEGIN, 32'd2, rand64(), rand64(), rand64(), '0);
    issue(ksct_pkg::ACT_BEGIN, 32'd0, rand64(), rand64(), rand64(), '0);
    issue(ksct_pkg::ACT_LOOKUP, 32'd2, rand64(), rand64(), rand64(), rand64());
    issue(ksct_pkg::ACT_RESOLVE, 32'd2, rand64(), rand64(), rand64(), rand64());
    issue(ksct_pkg::ACT_RESOLVE, 32'd2, rand64(), rand64(), rand64(), rand64());
    issue(ksct_pkg::ACT_REMOVE, 32'd3, rand64(), rand64(), rand64(), rand64());
    issue(ksct_pkg::ACT_CREATE, '0, rand64(), '0, '1, rand64());
    issue(ksct_pkg::ACT_LOOKUP, 32'd0, rand64(), rand64(), rand64(), rand64());
    issue(ksct_pkg::ACT_LOOKUP, '1, rand64(), rand64(), rand64(), rand64());
    issue(ACT_RSVD_6, 32'd1, rand64(), rand64(), rand64(), rand64());
    issue(ACT_RSVD_7, 32'd4, rand64(), rand64(), rand64(), rand64());
    issue(ksct_pkg::ACT_REMOVE, 32'd3, rand64(), rand64(), rand64(), rand64());

    // random traffic, alternating fill-heavy and drain-heavy stretches
    create_w = 35;
    remove_w = 5;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 150 == 0) begin
        create_w = (create_w == 35) ? 10 : 35;
        remove_w = (remove_w == 5) ? 35 : 5;
      end
      if (n % 97 == 0) quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < create_w) act = ksct_pkg::ACT_CREATE;
      else if (r < create_w + remove_w) act = ksct_pkg::ACT_REMOVE;
      else if (r < 96) act = mid_acts[$urandom_range(0, 3)];
      else act = $urandom_range(0, 1) ? ACT_RSVD_6 : ACT_RSVD_7;
      issue(act, pick_key(), pick_tag(), pick_tag(), rand64(),
            ($urandom_range(0, 5) == 0) ? 64'd0 : rand64());
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (failures == 0 && outstanding == 0)
      $display("keyed_slot_table_with_cas_unit verification clean");
    else
      $display("keyed_slot_table_with_cas_unit verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/ksct_pkg.sv
rtl/ksct_ram.sv
rtl/ksct_ctrl.sv
rtl/ksct_dp.sv
rtl/keyed_slot_table_with_cas_unit.sv
tb/sv/ksct_result_checker.sv
tb/sv/keyed_slot_table_with_cas_unit_tb.sv
